FILE: design/bwl_pkg.sv
// ---------------------------------------------------------------------------
// bwl_pkg
// Shared types, constants and table-building functions for the band-limited
// wavetable lookup.
// ---------------------------------------------------------------------------
package bwl_pkg;

  localparam int PHASE_BITS    = 23;
  localparam int SAMPLE_W      = 16;
  localparam int MODE_W        = 2;
  localparam int HCOUNT_W      = 6;

  localparam int TABLE_SIZE    = 1024;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int FRAC_W        = PHASE_BITS - IDX_W;
  localparam int HALF_SIZE     = TABLE_SIZE / 2;
  localparam int QTR_SIZE      = TABLE_SIZE / 4;
  localparam int QTR_W         = $clog2(QTR_SIZE + 1);

  localparam int MAX_HARMONICS = 32;
  localparam int SAW_TABLES    = MAX_HARMONICS;
  localparam int TRI_TABLES    = (MAX_HARMONICS + 1) / 2;
  localparam int SAW_TW        = $clog2(SAW_TABLES);
  localparam int TRI_TW        = $clog2(TRI_TABLES);
  localparam int SAW_DEPTH     = SAW_TABLES * TABLE_SIZE;
  localparam int TRI_DEPTH     = TRI_TABLES * TABLE_SIZE;
  localparam int SAW_AW        = SAW_TW + IDX_W;
  localparam int TRI_AW        = TRI_TW + IDX_W;

  localparam int Q_FRAC        = 30;
  localparam int COEF_W        = 30;
  localparam int MAG_W         = Q_FRAC + 1;
  localparam int PROD_W        = COEF_W + Q_FRAC;
  localparam int ACC_W         = 37;
  localparam int ROUND_SHIFT   = Q_FRAC - (SAMPLE_W - 2);

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [COEF_W-1:0] TWO_OVER_PI_Q30    = 30'd683565276;
  localparam logic [COEF_W-1:0] EIGHT_OVER_PI2_Q30 = 30'd870342340;

  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRI    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAW    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd3;

  typedef struct packed {
    logic             neg;
    logic [QTR_W-1:0] q;
  } fold_t;

  typedef struct packed {
    logic                saw_we;
    logic                tri_we;
    logic [SAW_AW-1:0]   saw_addr;
    logic [TRI_AW-1:0]   tri_addr;
    logic [SAMPLE_W-1:0] saw_data;
    logic [SAMPLE_W-1:0] tri_data;
  } tbl_wr_t;

  // first-quadrant sine magnitude in q30, taylor series, elaboration only
  function automatic logic [MAG_W-1:0] sine_mag(input int q);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 k;
    x    = (PI_Q30 * 64'(4 * q)) / 64'(2 * TABLE_SIZE);
    x2   = (x * x) >> Q_FRAC;
    term = x;
    sum  = $signed(x);
    for (k = 1; k < 16; k++) begin
      if (term != 64'd0) begin
        term = (term * x2) >> Q_FRAC;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
    return MAG_W'(sum);
  endfunction

  // table index to quarter-wave index and sign
  function automatic fold_t fold_index(input logic [IDX_W-1:0] m);
    logic [IDX_W-2:0] half;
    fold_t            f;
    half  = m[IDX_W-2:0];
    f.neg = m[IDX_W-1];
    if (IDX_W'(half) > IDX_W'(QTR_SIZE)) f.q = QTR_W'(IDX_W'(HALF_SIZE) - IDX_W'(half));
    else f.q = QTR_W'(half);
    return f;
  endfunction

  // q30 to sample format, round half away from zero, saturate
  function automatic logic [SAMPLE_W-1:0] round_q30(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r   = (mag + ACC_W'(2 ** (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (v[ACC_W-1]) begin
      if (r > ACC_W'(2 ** (SAMPLE_W - 1))) r = ACC_W'(2 ** (SAMPLE_W - 1));
      return SAMPLE_W'(-r);
    end
    if (r > ACC_W'(2 ** (SAMPLE_W - 1) - 1)) r = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
    return SAMPLE_W'(r);
  endfunction

endpackage

FILE: design/bandlimited_wavetable_lookup.sv
// ---------------------------------------------------------------------------
// bandlimited_wavetable_lookup
// Band-limited wavetable oscillator lookup with linear interpolation.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    mode, phase, harmonic_count
//   output   out_valid / out_ready  sample
//
// One transaction per cycle sustained while out_ready stays high; each input
// passes in order through the registered stages table memory read, select,
// multiply and round. After reset the saw and triangle memories are built;
// in_ready stays low until then. Each stage loads when it is empty or the
// stage after it moves, so a stall at the output backs up stage by stage.
// ---------------------------------------------------------------------------
module bandlimited_wavetable_lookup (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bwl_pkg::MODE_W-1:0]          mode,
  input  logic [bwl_pkg::PHASE_BITS-1:0]      phase,
  input  logic [bwl_pkg::HCOUNT_W-1:0]        harmonic_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bwl_pkg::SAMPLE_W-1:0] sample
);

  import bwl_pkg::*;

  localparam int WT_W   = FRAC_W + 1;
  localparam int MUL_W  = SAMPLE_W + WT_W - 1;
  localparam int NUM_W  = MUL_W + 1;
  localparam logic [SAMPLE_W-1:0] SQUARE_HI = round_q30(ACC_W'(Q30_ONE));

  tbl_wr_t                   wr;
  logic                      init_done;
  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic                      adv1;
  logic                      adv2;
  logic                      adv3;
  logic                      adv4;

  logic [HCOUNT_W-1:0]       h_sat;
  logic [HCOUNT_W-1:0]       h_m1;
  logic [SAW_TW-1:0]         saw_tbl;
  logic [TRI_TW-1:0]         tri_tbl;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          nxt;

  logic [SAMPLE_W-1:0]       saw_a;
  logic [SAMPLE_W-1:0]       saw_b;
  logic [SAMPLE_W-1:0]       tri_a;
  logic [SAMPLE_W-1:0]       tri_b;

  logic [MODE_W-1:0]         s1_mode;
  logic                      s1_zero;
  logic [IDX_W-1:0]          s1_idx;
  logic [FRAC_W-1:0]         s1_frac;
  logic [IDX_W-1:0]          s1_nxt;
  logic [SAMPLE_W-1:0]       sine_tbl [QTR_SIZE+1];
  fold_t                     f0;
  fold_t                     f1;
  logic [SAMPLE_W-1:0]       sine0;
  logic [SAMPLE_W-1:0]       sine1;
  logic [SAMPLE_W-1:0]       square0;
  logic [SAMPLE_W-1:0]       square1;
  logic [SAMPLE_W-1:0]       r0_next;
  logic [SAMPLE_W-1:0]       r1_next;

  logic signed [SAMPLE_W-1:0] s2_r0;
  logic signed [SAMPLE_W-1:0] s2_r1;
  logic [FRAC_W-1:0]         s2_frac;
  logic [WT_W-1:0]           wt0;
  logic signed [MUL_W-1:0]   p0_next;
  logic signed [MUL_W-1:0]   p1_next;

  logic signed [MUL_W-1:0]   s3_p0;
  logic signed [MUL_W-1:0]   s3_p1;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          mag;
  logic [NUM_W-1:0]          rnd;
  logic [SAMPLE_W-1:0]       sample_next;

  for (genvar g = 0; g <= QTR_SIZE; g++) begin : g_sine
    localparam logic [SAMPLE_W-1:0] Val = round_q30(ACC_W'(sine_mag(g)));
    assign sine_tbl[g] = Val;
  end

  // stage handshake
  assign adv4     = !out_valid || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = (!v1 || adv2) && init_done;
  assign in_ready = adv1;

  // table select and read addresses
  assign h_sat   = (harmonic_count > HCOUNT_W'(MAX_HARMONICS)) ?
                   HCOUNT_W'(MAX_HARMONICS) : harmonic_count;
  assign h_m1    = h_sat - HCOUNT_W'(1);
  assign saw_tbl = h_m1[SAW_TW-1:0];
  assign tri_tbl = h_m1[SAW_TW-1:1];
  assign idx     = phase[PHASE_BITS-1 -: IDX_W];
  assign nxt     = idx + IDX_W'(1);

  bwl_table_init u_init (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .done (init_done)
  );

  bwl_ram #(.WIDTH(SAMPLE_W), .DEPTH(SAW_DEPTH)) u_saw_ram (
    .clk     (clk),
    .we      (wr.saw_we),
    .waddr   (wr.saw_addr),
    .wdata   (wr.saw_data),
    .re      (adv1),
    .raddr_a ({saw_tbl, idx}),
    .raddr_b ({saw_tbl, nxt}),
    .rdata_a (saw_a),
    .rdata_b (saw_b)
  );

  bwl_ram #(.WIDTH(SAMPLE_W), .DEPTH(TRI_DEPTH)) u_tri_ram (
    .clk     (clk),
    .we      (wr.tri_we),
    .waddr   (wr.tri_addr),
    .wdata   (wr.tri_data),
    .re      (adv1),
    .raddr_a ({tri_tbl, idx}),
    .raddr_b ({tri_tbl, nxt}),
    .rdata_a (tri_a),
    .rdata_b (tri_b)
  );

  // stage 1: pick the two neighbor entries
  assign s1_nxt  = s1_idx + IDX_W'(1);
  assign f0      = fold_index(s1_idx);
  assign f1      = fold_index(s1_nxt);
  assign sine0   = f0.neg ? -sine_tbl[f0.q] : sine_tbl[f0.q];
  assign sine1   = f1.neg ? -sine_tbl[f1.q] : sine_tbl[f1.q];
  assign square0 = s1_idx[IDX_W-1] ? -SQUARE_HI : SQUARE_HI;
  assign square1 = s1_nxt[IDX_W-1] ? -SQUARE_HI : SQUARE_HI;

  always_comb begin
    unique case (s1_mode)
      MODE_SINE: begin
        r0_next = sine0;
        r1_next = sine1;
      end
      MODE_TRI: begin
        r0_next = tri_a;
        r1_next = tri_b;
      end
      MODE_SAW: begin
        r0_next = saw_a;
        r1_next = saw_b;
      end
      MODE_SQUARE: begin
        r0_next = square0;
        r1_next = square1;
      end
      default: begin
        r0_next = '0;
        r1_next = '0;
      end
    endcase
    if (s1_zero) begin
      r0_next = '0;
      r1_next = '0;
    end
  end

  // stage 2: weight both entries
  assign wt0     = WT_W'(2 ** FRAC_W) - {1'b0, s2_frac};
  assign p0_next = s2_r0 * $signed({1'b0, wt0});
  assign p1_next = s2_r1 * $signed({1'b0, s2_frac});

  // stage 3: sum, round half away from zero, saturate
  assign num = NUM_W'(s3_p0) + NUM_W'(s3_p1);
  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rnd = (mag + NUM_W'(2 ** (FRAC_W - 1))) >> FRAC_W;

  always_comb begin
    if (num[NUM_W-1]) begin
      if (rnd > NUM_W'(2 ** (SAMPLE_W - 1))) sample_next = SAMPLE_W'(2 ** (SAMPLE_W - 1));
      else sample_next = SAMPLE_W'(-rnd);
    end else begin
      if (rnd > NUM_W'(2 ** (SAMPLE_W - 1) - 1)) sample_next = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
      else sample_next = SAMPLE_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_mode <= mode;
      s1_zero <= harmonic_count == '0;
      s1_idx  <= idx;
      s1_frac <= phase[FRAC_W-1:0];
    end
    if (adv2) begin
      s2_r0   <= $signed(r0_next);
      s2_r1   <= $signed(r1_next);
      s2_frac <= s1_frac;
    end
    if (adv3) begin
      s3_p0 <= p0_next;
      s3_p1 <= p1_next;
    end
    if (adv4) begin
      sample <= $signed(sample_next);
    end
  end

endmodule

FILE: design/bwl_ram.sv
// ---------------------------------------------------------------------------
// bwl_ram
// Generic RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module bwl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/bwl_div.sv
// ---------------------------------------------------------------------------
// bwl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bwl_div #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    partial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign partial  = {rem, quo[DIVIDEND_W-1]};
  assign diff     = partial - {1'b0, dvs};
  assign fits     = partial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
    end
  end

endmodule

FILE: design/bwl_table_init.sv
// ---------------------------------------------------------------------------
// bwl_table_init
// Builds the band-limited saw and triangle tables after reset, one harmonic
// partial sum per step, and writes them into the table memories.
// ---------------------------------------------------------------------------
module bwl_table_init (
  input  logic             clk,
  input  logic             rst,
  output bwl_pkg::tbl_wr_t wr,
  output logic             done
);

  import bwl_pkg::*;

  localparam int DIV_W = 10;

  localparam logic [2:0] ST_IDX   = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_WR    = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]              state;
  logic [IDX_W-1:0]        j;
  logic [SAW_TW-1:0]       t;
  logic [MAG_W-1:0]        mag_saw;
  logic [MAG_W-1:0]        mag_tri;
  logic                    neg_saw;
  logic                    neg_tri;
  logic [DIV_W-1:0]        dvs_tri;
  logic [PROD_W-1:0]       prod_saw;
  logic [PROD_W-1:0]       prod_tri;
  logic signed [ACC_W-1:0] acc_saw;
  logic signed [ACC_W-1:0] acc_tri;

  logic [MAG_W-1:0]        sine_qtr [QTR_SIZE+1];
  logic [SAW_TW:0]         h;
  logic [SAW_TW-1:0]       ht;
  logic [IDX_W-1:0]        m_saw;
  logic [IDX_W-1:0]        m_tri;
  fold_t                   f_saw;
  fold_t                   f_tri;
  logic                    start;
  logic                    busy_saw;
  logic                    busy_tri;
  logic [Q_FRAC-1:0]       quo_saw;
  logic [Q_FRAC-1:0]       quo_tri;
  logic signed [ACC_W-1:0] term_saw;
  logic signed [ACC_W-1:0] term_tri;
  logic                    tri_live;

  for (genvar g = 0; g <= QTR_SIZE; g++) begin : g_sine
    localparam logic [MAG_W-1:0] Mag = sine_mag(g);
    assign sine_qtr[g] = Mag;
  end

  assign h        = {1'b0, t} + (SAW_TW + 1)'(1);
  assign ht       = {t[SAW_TW-2:0], 1'b1};
  assign m_saw    = IDX_W'(h * j);
  assign m_tri    = IDX_W'(ht * j);
  assign f_saw    = fold_index(m_saw);
  assign f_tri    = fold_index(m_tri);
  assign start    = state == ST_START;
  assign term_saw = $signed(ACC_W'(quo_saw));
  assign term_tri = $signed(ACC_W'(quo_tri));
  assign tri_live = t < SAW_TW'(TRI_TABLES);
  assign done     = state == ST_DONE;

  bwl_div #(.DIVIDEND_W(Q_FRAC), .DIVISOR_W(DIV_W)) u_div_saw (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (prod_saw[PROD_W-1:Q_FRAC]),
    .divisor  (DIV_W'(h)),
    .busy     (busy_saw),
    .quotient (quo_saw)
  );

  bwl_div #(.DIVIDEND_W(Q_FRAC), .DIVISOR_W(DIV_W)) u_div_tri (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (prod_tri[PROD_W-1:Q_FRAC]),
    .divisor  (dvs_tri),
    .busy     (busy_tri),
    .quotient (quo_tri)
  );

  always_comb begin
    wr          = '0;
    wr.saw_addr = {t, j};
    wr.tri_addr = {t[TRI_TW-1:0], j};
    wr.saw_data = round_q30(acc_saw);
    wr.tri_data = round_q30(acc_tri);
    wr.saw_we   = state == ST_WR;
    wr.tri_we   = (state == ST_WR) && tri_live;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDX;
      j       <= '0;
      t       <= '0;
      acc_saw <= '0;
      acc_tri <= '0;
    end else begin
      unique case (state)
        ST_IDX:   state <= ST_MUL;
        ST_MUL:   state <= ST_START;
        ST_START: state <= ST_DIV;
        ST_DIV: begin
          if (!busy_saw && !busy_tri) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc_saw <= neg_saw ? acc_saw - term_saw : acc_saw + term_saw;
          if (tri_live) begin
            // odd table positions subtract
            acc_tri <= (neg_tri ^ t[0]) ? acc_tri - term_tri : acc_tri + term_tri;
          end
          state <= ST_WR;
        end
        ST_WR: begin
          if (t == SAW_TW'(SAW_TABLES - 1)) begin
            t       <= '0;
            acc_saw <= '0;
            acc_tri <= '0;
            if (j == IDX_W'(TABLE_SIZE - 1)) begin
              state <= ST_DONE;
            end else begin
              j     <= j + IDX_W'(1);
              state <= ST_IDX;
            end
          end else begin
            t     <= t + SAW_TW'(1);
            state <= ST_IDX;
          end
        end
        ST_DONE:  state <= ST_DONE;
        default:  state <= ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDX) begin
      mag_saw <= sine_qtr[f_saw.q];
      mag_tri <= sine_qtr[f_tri.q];
      neg_saw <= f_saw.neg;
      neg_tri <= f_tri.neg;
      dvs_tri <= DIV_W'(ht) * DIV_W'(ht);
    end
    if (state == ST_MUL) begin
      prod_saw <= PROD_W'(TWO_OVER_PI_Q30) * PROD_W'(mag_saw);
      prod_tri <= PROD_W'(EIGHT_OVER_PI2_Q30) * PROD_W'(mag_tri);
    end
  end

endmodule
